// ===== rtl/rbvs_pkg.sv =====
// Shared constants, status codes and a helper function for the bucketed value store.
`timescale 1ns / 1ps

package rbvs_pkg;

    localparam int MAX_BUCKETS      = 8;
    localparam int SLOTS_PER_BUCKET = 64;
    localparam int VALUE_LIMIT      = 1000;

    localparam int BUCKET_W = $clog2(MAX_BUCKETS);
    localparam int SLOT_W   = $clog2(SLOTS_PER_BUCKET);
    localparam int FILL_W   = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int ADDR_W   = BUCKET_W + SLOT_W;
    localparam int DEPTH    = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int VALUE_W  = 10;
    localparam int COUNT_W  = 4;
    localparam int TOTAL_W  = 10;
    localparam int STATUS_W = 3;
    localparam int THR_W    = VALUE_W + BUCKET_W + 1;

    localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd5;

    // Width of one bucket's span of values: 1000 divided by the bucket count.
    function automatic logic [VALUE_W-1:0] bucket_span(input logic [COUNT_W-1:0] count);
        logic [VALUE_W-1:0] span;
        case (count)
            4'd1: span = 10'd1000;
            4'd2: span = 10'd500;
            4'd3: span = 10'd333;
            4'd4: span = 10'd250;
            4'd5: span = 10'd200;
            4'd6: span = 10'd166;
            4'd7: span = 10'd142;
            4'd8: span = 10'd125;
            default: span = 10'd1000;
        endcase
        return span;
    endfunction

endpackage

// ===== rtl/range_bucketed_value_store.sv =====
// Top level of the range-partitioned bucketed value store.
`timescale 1ns / 1ps

// Values 0 to 999 are kept in up to eight buckets of 64 slots each, held in one
// 512-entry memory with a write port and a registered read port. An add request
// passes through the decode and response states to the output register, and so
// does a remove request on an empty bucket. A remove request on a bucket holding
// entries adds a pass state in which the bucket is read once, front to back,
// through the single read port, and entries after the match are written one slot
// down as they stream past. The next request is taken the cycle after the result
// is loaded, even while that result still waits in the output register. Writing
// the bucket count takes effect on the next request; stored entries are not moved.
module range_bucketed_value_store
    import rbvs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [BUCKET_W-1:0] m_bucket,
    output logic [FILL_W-1:0]   m_bucket_fill,
    output logic [TOTAL_W-1:0]  m_total_count
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_PASS   = 2'd2;
    localparam logic [1:0] ST_RESP   = 2'd3;

    logic [1:0]          state_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [FILL_W-1:0]   fill_reg [MAX_BUCKETS];
    logic [TOTAL_W-1:0]  total_reg;

    logic                mode_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [FILL_W-1:0]   cur_fill_reg;
    logic [FILL_W-1:0]   rd_idx_reg;
    logic                rd_vld_reg;
    logic [SLOT_W-1:0]   rd_didx_reg;
    logic                found_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [BUCKET_W-1:0] res_bucket_reg;
    logic [FILL_W-1:0]   res_fill_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [BUCKET_W-1:0] m_bucket_reg;
    logic [FILL_W-1:0]   m_fill_reg;
    logic [TOTAL_W-1:0]  m_total_reg;

    logic [VALUE_W-1:0]  store_mem [DEPTH];
    logic [VALUE_W-1:0]  rd_data_reg;

    logic [VALUE_W-1:0]  span;
    logic [BUCKET_W:0]   dec_bucket;
    logic                dec_bad;
    logic [FILL_W-1:0]   dec_fill;
    logic [BUCKET_W-1:0] dec_b;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [VALUE_W-1:0]  wr_data;
    logic                pass_match;
    logic                pass_last;
    logic                out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // The bucket index is the number of span boundaries at or below the value.
    always_comb begin
        logic [THR_W-1:0] thr;
        span       = bucket_span(count_reg);
        dec_bucket = '0;
        for (int k = 1; k < MAX_BUCKETS; k++) begin
            thr = THR_W'(k) * THR_W'(span);
            if (THR_W'(value_reg) >= thr) begin
                dec_bucket = dec_bucket + 1'b1;
            end
        end
        dec_b    = dec_bucket[BUCKET_W-1:0];
        dec_bad  = (value_reg >= VALUE_W'(VALUE_LIMIT)) || (count_reg == '0) ||
                   (count_reg > COUNT_W'(MAX_BUCKETS)) ||
                   (COUNT_W'(dec_bucket) >= count_reg);
        dec_fill = fill_reg[dec_b];
    end

    // Remove pass: reads run ahead, each returned entry is compared, and once the
    // match is seen every later entry is written back one slot lower.
    assign rd_en      = (state_reg == ST_PASS) && (rd_idx_reg < cur_fill_reg);
    assign rd_addr    = {bucket_reg, rd_idx_reg[SLOT_W-1:0]};
    assign pass_match = rd_vld_reg && !found_reg && (rd_data_reg == value_reg);
    assign pass_last  = rd_vld_reg && ({1'b0, rd_didx_reg} == cur_fill_reg - 1'b1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {bucket_reg, rd_didx_reg - 1'b1};
        wr_data = rd_data_reg;
        if (state_reg == ST_DECODE) begin
            wr_en   = !dec_bad && !mode_reg && (dec_fill < FILL_W'(SLOTS_PER_BUCKET));
            wr_addr = {dec_b, dec_fill[SLOT_W-1:0]};
            wr_data = value_reg;
        end else if (state_reg == ST_PASS) begin
            wr_en   = rd_vld_reg && found_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= COUNT_RESET;
            total_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_BUCKETS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            // A result loaded in the response state sets valid instead.
            if (m_valid_reg && m_ready && (state_reg != ST_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg  <= rd_en;
            rd_didx_reg <= rd_idx_reg[SLOT_W-1:0];
            if (rd_en) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_mode;
                        value_reg <= s_value;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    bucket_reg   <= dec_b;
                    cur_fill_reg <= dec_fill;
                    rd_idx_reg   <= '0;
                    found_reg    <= 1'b0;
                    if (dec_bad) begin
                        res_status_reg <= STATUS_RANGE;
                        res_bucket_reg <= '0;
                        res_fill_reg   <= '0;
                        state_reg      <= ST_RESP;
                    end else if (!mode_reg) begin
                        res_bucket_reg <= dec_b;
                        state_reg      <= ST_RESP;
                        if (dec_fill >= FILL_W'(SLOTS_PER_BUCKET)) begin
                            res_status_reg <= STATUS_FULL;
                            res_fill_reg   <= dec_fill;
                        end else begin
                            res_status_reg  <= STATUS_ADDED;
                            res_fill_reg    <= dec_fill + 1'b1;
                            fill_reg[dec_b] <= dec_fill + 1'b1;
                            total_reg       <= total_reg + 1'b1;
                        end
                    end else if (dec_fill == '0) begin
                        res_status_reg <= STATUS_NOT_FOUND;
                        res_bucket_reg <= dec_b;
                        res_fill_reg   <= dec_fill;
                        state_reg      <= ST_RESP;
                    end else begin
                        res_bucket_reg <= dec_b;
                        res_fill_reg   <= dec_fill;
                        state_reg      <= ST_PASS;
                    end
                end
                ST_PASS: begin
                    if (pass_match) begin
                        found_reg <= 1'b1;
                    end
                    if (pass_last) begin
                        state_reg <= ST_RESP;
                        if (found_reg || pass_match) begin
                            res_status_reg       <= STATUS_REMOVED;
                            res_fill_reg         <= cur_fill_reg - 1'b1;
                            fill_reg[bucket_reg] <= cur_fill_reg - 1'b1;
                            total_reg            <= total_reg - 1'b1;
                        end else begin
                            res_status_reg <= STATUS_NOT_FOUND;
                        end
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_bucket_reg <= res_bucket_reg;
                        m_fill_reg   <= res_fill_reg;
                        m_total_reg  <= total_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_bucket      = m_bucket_reg;
    assign m_bucket_fill = m_fill_reg;
    assign m_total_count = m_total_reg;

endmodule

// ===== rtl/rbvs_checker.sv =====
// Port-level checks for the bucketed value store, bound to the top level.
`timescale 1ns / 1ps

module rbvs_checker
    import rbvs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                cfg_wr_en,
    input logic [COUNT_W-1:0]  cfg_wr_data,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_mode,
    input logic [VALUE_W-1:0]  s_value,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [BUCKET_W-1:0] m_bucket,
    input logic [FILL_W-1:0]   m_bucket_fill,
    input logic [TOTAL_W-1:0]  m_total_count
);

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_bucket) &&
        $stable(m_bucket_fill) && $stable(m_total_count))
        else $error("result changed while stalled");

    // An out-of-range request reports no bucket and no fill.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_RANGE) |-> (m_bucket == '0) && (m_bucket_fill == '0))
        else $error("range error with nonzero bucket or fill");

    // A full bucket is reported only at its slot count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_FULL) |-> m_bucket_fill == FILL_W'(SLOTS_PER_BUCKET))
        else $error("full status with fill below capacity");

    // After an add the bucket holds at least one entry and so does the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_ADDED) |->
        (m_bucket_fill != '0) && (m_total_count >= TOTAL_W'(m_bucket_fill)))
        else $error("add result with inconsistent counts");

    // No status code beyond the range error appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= STATUS_RANGE)
        else $error("undefined status code");

endmodule

bind range_bucketed_value_store rbvs_checker u_rbvs_checker (.*);
